FILE: rtl/uer_pkg.sv
// ============================================================================
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Field widths, sequencer states, config indexes, stage words and the
// fixed-point constants that turn a pulse width into millimetres.
// ============================================================================
package uer_pkg;

    // Timestamp and register widths
    localparam int TIME_W    = 32;
    localparam int TMO_W     = 20;
    localparam int SPEED_W   = 9;
    localparam int DIST_W    = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = TMO_W;

    // Reset values of the config registers
    localparam logic [TMO_W-1:0]   TMO_RESET   = TMO_W'(30000);
    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(343);

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED   = 2'd2;

    // Event codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_EDGE = 1'b1;

    // Distance = width * speed / 2000 = ((width * speed) >> 4) / 125.
    // Divide by 125 through a reciprocal: exact for every 25-bit dividend.
    localparam int PROD_W      = TMO_W + SPEED_W;
    localparam int PRE_SHIFT   = 4;
    localparam int QIN_W       = PROD_W - PRE_SHIFT;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] RECIP_125 = RECIP_W'(34359739);
    localparam int QMUL_W      = QIN_W + RECIP_W;
    localparam int QUO_W       = QMUL_W - RECIP_SHIFT;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_TRIG  = 4'b0010,
        MODE_WRISE = 4'b0100,
        MODE_WFALL = 4'b1000
    } mode_t;

    // Word leaving the sequencer stage
    typedef struct packed {
        logic              trigger;
        logic              srst;
        logic              fall;
        logic [TIME_W-1:0] width;
    } seq_word_t;

    // Word after timeout check and product
    typedef struct packed {
        logic              trigger;
        logic              srst;
        logic              tmo;
        logic              valid;
        logic [PROD_W-1:0] prod;
    } prod_word_t;

    // Result word
    typedef struct packed {
        logic              trigger_level;
        logic              distance_valid;
        logic [DIST_W-1:0] distance_mm;
        logic              echo_timeout;
        logic              sensor_reset;
    } result_t;

endpackage

FILE: rtl/uer_event_if.sv
// ============================================================================
// uer_event_if: input event channel
// Carries one tick or echo edge with its timestamp per word.
// ============================================================================
interface uer_event_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic                      echo_level;
    logic [uer_pkg::TIME_W-1:0] time_us;

    modport source (output valid, output func, output echo_level, output time_us,
                    input ready);
    modport sink   (input valid, input func, input echo_level, input time_us,
                    output ready);
endinterface

FILE: rtl/uer_result_if.sv
// ============================================================================
// uer_result_if: result channel
// Carries trigger level, distance and status flags per word.
// ============================================================================
interface uer_result_if;
    logic                       valid;
    logic                       ready;
    logic                       trigger_level;
    logic                       distance_valid;
    logic [uer_pkg::DIST_W-1:0] distance_mm;
    logic                       echo_timeout;
    logic                       sensor_reset;

    modport source (output valid, output trigger_level, output distance_valid,
                    output distance_mm, output echo_timeout, output sensor_reset,
                    input ready);
    modport sink   (input valid, input trigger_level, input distance_valid,
                    input distance_mm, input echo_timeout, input sensor_reset,
                    output ready);
endinterface

FILE: rtl/uer_cfg_if.sv
// ============================================================================
// uer_cfg_if: configuration write channel
// Carries a register index and its write data per word.
// ============================================================================
interface uer_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [uer_pkg::CFG_IDX_W-1:0] index;
    logic [uer_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/uer_seq.sv
// ============================================================================
// uer_seq: ranging sequencer
// Holds mode, trigger and rise time; updates them on each accepted event
// and registers the sequencer word with the raw pulse width.
// ============================================================================
module uer_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic                        enable,
    input  logic                        func,
    input  logic                        echo_level,
    input  logic [uer_pkg::TIME_W-1:0]  time_us,
    output uer_pkg::seq_word_t          word
);

    uer_pkg::mode_t              mode_reg, mode_next, mode_cur;
    logic                        trig_reg, trig_next, trig_cur;
    logic [uer_pkg::TIME_W-1:0]  rise_reg, rise_next;
    uer_pkg::seq_word_t          word_reg, word_next;

    always_comb
    begin
        // Leaving idle enters the trigger state with the trigger high
        mode_cur  = (mode_reg == uer_pkg::MODE_IDLE) ? uer_pkg::MODE_TRIG : mode_reg;
        trig_cur  = (mode_reg == uer_pkg::MODE_IDLE) ? 1'b1 : trig_reg;
        mode_next = mode_cur;
        trig_next = trig_cur;
        rise_next = rise_reg;
        word_next = '0;
        word_next.width = time_us - rise_reg;

        if (!enable)
        begin
            mode_next = uer_pkg::MODE_IDLE;
            trig_next = 1'b1;
        end
        else if (func == uer_pkg::FUNC_TICK)
        begin
            case (mode_cur)
                uer_pkg::MODE_TRIG:
                begin
                    mode_next = uer_pkg::MODE_WRISE;
                    trig_next = 1'b0;
                end
                uer_pkg::MODE_WRISE, uer_pkg::MODE_WFALL:
                begin
                    mode_next     = uer_pkg::MODE_TRIG;
                    trig_next     = 1'b1;
                    word_next.srst = 1'b1;
                end
                default:
                begin
                    mode_next = mode_cur;
                end
            endcase
        end
        else if (mode_cur inside {uer_pkg::MODE_WRISE, uer_pkg::MODE_WFALL})
        begin
            if (echo_level)
            begin
                trig_next = 1'b1;
                rise_next = time_us;
                mode_next = uer_pkg::MODE_WFALL;
            end
            else
            begin
                word_next.fall = 1'b1;
                mode_next      = uer_pkg::MODE_TRIG;
            end
        end
        word_next.trigger = trig_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= uer_pkg::MODE_IDLE;
            trig_reg <= 1'b1;
            rise_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            trig_reg <= trig_next;
            rise_reg <= rise_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

FILE: rtl/uer_scale.sv
// ============================================================================
// uer_scale: width check and distance conversion
// Checks the width against the timeout, forms width * speed, then divides
// by 2000 through a reciprocal multiply and saturates into the result word.
// ============================================================================
module uer_scale (
    input  logic                         clk,
    input  logic                         load_prod,
    input  logic                         load_res,
    input  logic [uer_pkg::TMO_W-1:0]    timeout,
    input  logic [uer_pkg::SPEED_W-1:0]  speed,
    input  uer_pkg::seq_word_t           seq,
    output uer_pkg::result_t             result
);

    uer_pkg::prod_word_t                 prod_reg, prod_next;
    uer_pkg::result_t                    res_reg, res_next;
    logic                                over;
    logic [uer_pkg::QMUL_W-1:0]          qmul;
    logic [uer_pkg::QUO_W-1:0]           quo;

    always_comb
    begin
        over              = seq.width > uer_pkg::TIME_W'(timeout);
        prod_next.trigger = seq.trigger;
        prod_next.srst    = seq.srst;
        prod_next.tmo     = seq.fall & over;
        prod_next.valid   = seq.fall & ~over;
        // Width fits the timeout field whenever the distance is used
        prod_next.prod    = uer_pkg::PROD_W'(seq.width[uer_pkg::TMO_W-1:0])
                            * uer_pkg::PROD_W'(speed);
    end

    always_comb
    begin
        qmul = uer_pkg::QMUL_W'(prod_reg.prod[uer_pkg::PROD_W-1:uer_pkg::PRE_SHIFT])
               * uer_pkg::QMUL_W'(uer_pkg::RECIP_125);
        quo  = qmul[uer_pkg::QMUL_W-1:uer_pkg::RECIP_SHIFT];
        res_next.trigger_level  = prod_reg.trigger;
        res_next.distance_valid = prod_reg.valid;
        res_next.echo_timeout   = prod_reg.tmo;
        res_next.sensor_reset   = prod_reg.srst;
        if (!prod_reg.valid)
        begin
            res_next.distance_mm = '0;
        end
        else if (quo > uer_pkg::QUO_W'(uer_pkg::DIST_MAX))
        begin
            res_next.distance_mm = uer_pkg::DIST_MAX;
        end
        else
        begin
            res_next.distance_mm = quo[uer_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            prod_reg <= prod_next;
        end
        if (load_res)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

FILE: rtl/ultrasonic_echo_ranger_top.sv
// ============================================================================
// ultrasonic_echo_ranger_top: ultrasonic echo ranger sequencer
// Config registers, pipeline control and the two datapath stages.
// ============================================================================
// The block takes one event word per clock (an interval tick or an echo
// edge with its microsecond timestamp) and returns exactly one result word
// per event, in order. Throughput is one event per cycle: the sequencer
// state (mode, trigger, rise time) updates at acceptance, and the distance
// math runs behind it in two more stages, one for the timeout check and
// width * speed product and one for the divide by 2000 done as a
// reciprocal multiply. The pipeline stalls only when the result side
// withholds ready and all three stages are full. Config writes are
// always taken and should only be issued while no event is in flight.
// After reset the ranger is disabled with the trigger high.
module ultrasonic_echo_ranger_top (
    input  logic          clk,
    input  logic          rst_n,
    uer_cfg_if.sink       cfg,
    uer_event_if.sink     evt,
    uer_result_if.source  res
);

    // Config registers
    logic                         enable_reg;
    logic [uer_pkg::TMO_W-1:0]    timeout_reg;
    logic [uer_pkg::SPEED_W-1:0]  speed_reg;

    // Stage valids and load strobes
    logic v_seq_reg, v_prod_reg, v_res_reg;
    logic load_seq, load_prod, load_res, accept;

    uer_pkg::seq_word_t seq_word;
    uer_pkg::result_t   result;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            timeout_reg <= uer_pkg::TMO_RESET;
            speed_reg   <= uer_pkg::SPEED_RESET;
        end
        else if (cfg.valid)
        begin
            // Drop writes to indexes past the register list
            case (cfg.index)
                uer_pkg::CFG_ENABLE:  enable_reg  <= cfg.data[0];
                uer_pkg::CFG_TIMEOUT: timeout_reg <= cfg.data;
                uer_pkg::CFG_SPEED:   speed_reg   <= cfg.data[uer_pkg::SPEED_W-1:0];
                default:              enable_reg  <= enable_reg;
            endcase
        end
    end

    // Advance a stage when the one after it is empty or moving
    assign load_res  = !v_res_reg  || res.ready;
    assign load_prod = !v_prod_reg || load_res;
    assign load_seq  = !v_seq_reg  || load_prod;
    assign evt.ready = load_seq;
    assign accept    = evt.valid && load_seq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_seq_reg  <= 1'b0;
            v_prod_reg <= 1'b0;
            v_res_reg  <= 1'b0;
        end
        else
        begin
            if (load_seq)
            begin
                v_seq_reg <= evt.valid;
            end
            if (load_prod)
            begin
                v_prod_reg <= v_seq_reg;
            end
            if (load_res)
            begin
                v_res_reg <= v_prod_reg;
            end
        end
    end

    // Hold state and raw width for each accepted event
    uer_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .enable     (enable_reg),
        .func       (evt.func),
        .echo_level (evt.echo_level),
        .time_us    (evt.time_us),
        .word       (seq_word)
    );

    // Check timeout and convert width to millimetres
    uer_scale u_scale (
        .clk       (clk),
        .load_prod (load_prod && v_seq_reg),
        .load_res  (load_res && v_prod_reg),
        .timeout   (timeout_reg),
        .speed     (speed_reg),
        .seq       (seq_word),
        .result    (result)
    );

    assign res.valid          = v_res_reg;
    assign res.trigger_level  = result.trigger_level;
    assign res.distance_valid = result.distance_valid;
    assign res.distance_mm    = result.distance_mm;
    assign res.echo_timeout   = result.echo_timeout;
    assign res.sensor_reset   = result.sensor_reset;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: ultrasonic echo ranger sequencer
// Drives tick and echo-edge words through the event channel. It mirrors the
// ranging sequence in a local predictor and checks every result word in order.
// The run steps through several register settings and idle patterns.
// ============================================================================
module testbench;
    import uer_pkg::*;

    // Echo level codes carried with an edge
    localparam logic LVL_FALL = 1'b0;
    localparam logic LVL_RISE = 1'b1;

    // Register index past the end of the register list; writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Directed table: either a register write or an event word, with an
    // optional hand-typed expectation for rows that are obvious from the spec
    typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
        logic              func;
        logic              level;
        logic [TIME_W-1:0] stamp;
        logic              typed;
        result_t           want;
    } dir_row_t;

    // Hand-typed results: trigger high and nothing else, trigger low,
    // sensor reset, echo timeout, saturated distance
    localparam result_t R_NONE = '0;
    localparam result_t R_HIGH = '{1'b1, 1'b0, 18'd0, 1'b0, 1'b0};
    localparam result_t R_LOW  = '{1'b0, 1'b0, 18'd0, 1'b0, 1'b0};
    localparam result_t R_SRST = '{1'b1, 1'b0, 18'd0, 1'b0, 1'b1};
    localparam result_t R_TMO  = '{1'b1, 1'b0, 18'd0, 1'b1, 1'b0};
    localparam result_t R_SAT  = '{1'b1, 1'b1, DIST_MAX, 1'b0, 1'b0};

    localparam int DIR_N = 38;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // disabled after reset: events are dropped, trigger stays high
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_RISE, 32'h0000_0000, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'hFFFF_FFFF, 1'b1, R_HIGH},
        '{ROW_WRITE, CFG_ENABLE, 20'd1, FUNC_TICK, LVL_FALL, 32'h0, 1'b0, R_NONE},
        // first enabled word enters trigger state; an edge there is dropped
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'd123, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_FALL, 32'd200, 1'b1, R_LOW},
        // falling edge while waiting for rise uses the stored rise time
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_FALL, 32'd1000, 1'b0, R_NONE},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_FALL, 32'd1100, 1'b1, R_LOW},
        // rise, then a second rise that retakes the time, then a wrapped fall
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'hFFFF_FF00, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'hFFFF_FFF0, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_FALL, 32'h0000_0100, 1'b0, R_NONE},
        // tick in each wait state flags a sensor reset
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_RISE, 32'd2000, 1'b1, R_LOW},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_FALL, 32'd3000, 1'b1, R_SRST},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_FALL, 32'd4000, 1'b1, R_LOW},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'd5000, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_RISE, 32'd5500, 1'b1, R_SRST},
        // edge outside a wait state changes nothing
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_FALL, 32'd6000, 1'b1, R_HIGH},
        // width equal to the timeout is still a distance
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_FALL, 32'd7000, 1'b1, R_LOW},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'd100, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_FALL, 32'd30100, 1'b0, R_NONE},
        // one microsecond past the timeout
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_FALL, 32'd40000, 1'b1, R_LOW},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'd0, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_FALL, 32'd30001, 1'b1, R_TMO},
        // widest timeout and fastest speed: distance saturates
        '{ROW_WRITE, CFG_TIMEOUT, 20'hFFFFF, FUNC_TICK, LVL_FALL, 32'h0, 1'b0, R_NONE},
        '{ROW_WRITE, CFG_SPEED, 20'h001FF, FUNC_TICK, LVL_FALL, 32'h0, 1'b0, R_NONE},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_FALL, 32'd50, 1'b1, R_LOW},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'd0, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_FALL, 32'h000F_FFFF, 1'b1, R_SAT},
        // zero timeout and zero speed
        '{ROW_WRITE, CFG_TIMEOUT, 20'd0, FUNC_TICK, LVL_FALL, 32'h0, 1'b0, R_NONE},
        '{ROW_WRITE, CFG_SPEED, 20'd0, FUNC_TICK, LVL_FALL, 32'h0, 1'b0, R_NONE},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_FALL, 32'd3, 1'b1, R_LOW},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'd7, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_FALL, 32'd7, 1'b0, R_NONE},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_TICK, LVL_FALL, 32'd9, 1'b1, R_LOW},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'd7, 1'b1, R_HIGH},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_FALL, 32'd8, 1'b1, R_TMO},
        // spare index is dropped; enable write looks at bit 0 only
        '{ROW_WRITE, CFG_SPARE, 20'hFFFFF, FUNC_TICK, LVL_FALL, 32'h0, 1'b0, R_NONE},
        '{ROW_WRITE, CFG_ENABLE, 20'hFFFFE, FUNC_TICK, LVL_FALL, 32'h0, 1'b0, R_NONE},
        '{ROW_EVENT, CFG_ENABLE, 20'd0, FUNC_EDGE, LVL_RISE, 32'hA5A5_5A5A, 1'b1, R_HIGH}
    };

    logic clk = 1'b0;
    logic rst_n;

    uer_cfg_if    cfg_bus ();
    uer_event_if  evt_bus ();
    uer_result_if res_bus ();

    ultrasonic_echo_ranger_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .evt   (evt_bus),
        .res   (res_bus)
    );

    // Register mirror
    logic                en_reg;
    logic [TMO_W-1:0]    tmo_reg;
    logic [SPEED_W-1:0]  speed_reg;

    // Sequencer mirror
    mode_t               seq_mode;
    logic [TIME_W-1:0]   rise_stamp;
    logic                trig_q;
    logic                armed;

    // Results still owed by the block, oldest first
    result_t pending_results [$];

    // Idle pattern of the current phase, in percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned errors = 0;
    int unsigned n_results = 0;
    int unsigned n_dist = 0;
    int unsigned n_tmo = 0;
    int unsigned n_srst = 0;
    int unsigned n_sat = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Advance the sequencer mirror by one accepted event word and return
    // the result word it owes.
    function automatic result_t range_step(logic func, logic level,
                                           logic [TIME_W-1:0] stamp);
        result_t           r;
        logic [TIME_W-1:0] width;
        logic [63:0]       dist_mm;
        r = '0;
        if (!en_reg)
        begin
            seq_mode = MODE_IDLE;
            trig_q   = 1'b1;
            armed    = 1'b0;
        end
        else
        begin
            // first word after enabling enters trigger state, then runs normally
            if (!armed)
            begin
                armed    = 1'b1;
                seq_mode = MODE_TRIG;
                trig_q   = 1'b1;
            end
            if (func == FUNC_TICK)
            begin
                if (seq_mode == MODE_TRIG)
                begin
                    seq_mode = MODE_WRISE;
                    trig_q   = 1'b0;
                end
                else if (seq_mode == MODE_WRISE || seq_mode == MODE_WFALL)
                begin
                    seq_mode       = MODE_TRIG;
                    trig_q         = 1'b1;
                    r.sensor_reset = 1'b1;
                end
            end
            else if (seq_mode == MODE_WRISE || seq_mode == MODE_WFALL)
            begin
                if (level == LVL_RISE)
                begin
                    trig_q     = 1'b1;
                    rise_stamp = stamp;
                    seq_mode   = MODE_WFALL;
                end
                else
                begin
                    // width wraps with the timestamp
                    width = stamp - rise_stamp;
                    if (width > TIME_W'(tmo_reg))
                        r.echo_timeout = 1'b1;
                    else
                    begin
                        dist_mm = 64'(width) * 64'(speed_reg) / 64'd2000;
                        if (dist_mm > 64'(DIST_MAX))
                            dist_mm = 64'(DIST_MAX);
                        r.distance_valid = 1'b1;
                        r.distance_mm    = dist_mm[DIST_W-1:0];
                    end
                    seq_mode = MODE_TRIG;
                end
            end
        end
        r.trigger_level = trig_q;
        return r;
    endfunction

    // Send one event word, holding valid until the block takes it. A typed
    // expectation replaces the predicted one, but the mirror still advances.
    task automatic send_event(input logic func, input logic level,
                              input logic [TIME_W-1:0] stamp,
                              input logic typed, input result_t want);
        result_t got;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            evt_bus.valid <= 1'b0;
            @(posedge clk);
        end
        evt_bus.valid      <= 1'b1;
        evt_bus.func       <= func;
        evt_bus.echo_level <= level;
        evt_bus.time_us    <= stamp;
        do
            @(posedge clk);
        while (!evt_bus.ready);
        got = range_step(func, level, stamp);
        pending_results.push_back(typed ? want : got);
    endtask

    // Drop valid and hold until every owed result word has come back.
    task automatic settle_pipeline();
        evt_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write one register and update the mirror; unknown indexes are dropped.
    // Hold valid low before returning so back-to-back writes never drive
    // valid twice at one edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= index;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (index)
            CFG_ENABLE:  en_reg    = data[0];
            CFG_TIMEOUT: tmo_reg   = data[TMO_W-1:0];
            CFG_SPEED:   speed_reg = data[SPEED_W-1:0];
            default:     ;
        endcase
        @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Receiver: stall at the rate of the current phase
    initial
    begin
        res_bus.ready = 1'b1;
        forever
        begin
            @(posedge clk);
            res_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checker: every word taken is compared with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no event pending");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("trigger_level", 32'(want.trigger_level),
                              32'(res_bus.trigger_level));
                compare_field("distance_valid", 32'(want.distance_valid),
                              32'(res_bus.distance_valid));
                compare_field("distance_mm", 32'(want.distance_mm),
                              32'(res_bus.distance_mm));
                compare_field("echo_timeout", 32'(want.echo_timeout),
                              32'(res_bus.echo_timeout));
                compare_field("sensor_reset", 32'(want.sensor_reset),
                              32'(res_bus.sensor_reset));
                n_results++;
                if (want.distance_valid) n_dist++;
                if (want.distance_valid && want.distance_mm == DIST_MAX) n_sat++;
                if (want.echo_timeout) n_tmo++;
                if (want.sensor_reset) n_srst++;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [TIME_W-1:0]    now_us;
        logic [TIME_W-1:0]    rise_at;
        logic [TIME_W-1:0]    width;
        logic [CFG_DAT_W-1:0] tmo_val;
        logic [CFG_DAT_W-1:0] speed_val;
        int                   sent;

        // every input known from time zero, with reset held low at the start
        rst_n              = 1'b0;
        evt_bus.valid      = 1'b0;
        evt_bus.func       = FUNC_TICK;
        evt_bus.echo_level = LVL_FALL;
        evt_bus.time_us    = '0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = CFG_ENABLE;
        cfg_bus.data       = '0;

        en_reg     = 1'b0;
        tmo_reg    = TMO_RESET;
        speed_reg  = SPEED_RESET;
        seq_mode   = MODE_IDLE;
        rise_stamp = '0;
        trig_q     = 1'b1;
        armed      = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: walk the table; registers change only with the
        // pipeline empty
        foreach (DIR_ROWS[i])
        begin
            if (DIR_ROWS[i].kind == ROW_WRITE)
            begin
                settle_pipeline();
                write_reg(DIR_ROWS[i].index, DIR_ROWS[i].data);
            end
            else
                send_event(DIR_ROWS[i].func, DIR_ROWS[i].level, DIR_ROWS[i].stamp,
                           DIR_ROWS[i].typed, DIR_ROWS[i].want);
        end

        // Random part: eight phases, each with its own registers and idle
        // pattern. Most words form tick / rise / fall measurements with
        // random widths around the timeout; the rest is noise.
        now_us = $urandom();
        for (int p = 0; p < 8; p++)
        begin
            settle_pipeline();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            case (p)
                0: begin tmo_val = 20'd30000;   speed_val = 20'd343; end
                1: begin tmo_val = 20'hFFFFF;   speed_val = 20'd511; end
                2: begin tmo_val = 20'd0;       speed_val = 20'd300; end
                3: begin tmo_val = 20'($urandom_range(1000, 60000)); speed_val = 20'd400; end
                4: begin tmo_val = 20'($urandom()); speed_val = 20'($urandom()); end
                5: begin tmo_val = 20'd1000000; speed_val = 20'd400; end
                6: begin tmo_val = 20'd500;     speed_val = 20'd0;   end
                default: begin tmo_val = 20'd30000; speed_val = 20'($urandom_range(300, 400)); end
            endcase

            // drop enable, show a couple of words to the idle block, then
            // load the phase's registers and enable again
            write_reg(CFG_ENABLE, 20'($urandom()) & ~20'd1);
            repeat (2)
                send_event(1'($urandom()), 1'($urandom()), $urandom(), 1'b0, R_NONE);
            settle_pipeline();
            write_reg(CFG_TIMEOUT, tmo_val);
            write_reg(CFG_SPEED, speed_val);
            write_reg(CFG_ENABLE, 20'($urandom()) | 20'd1);

            sent = 0;
            while (sent < 140)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    now_us += $urandom_range(1, 5000);
                    send_event(FUNC_TICK, 1'($urandom()), now_us, 1'b0, R_NONE);
                    now_us += $urandom_range(1, 2000);
                    rise_at = now_us;
                    send_event(FUNC_EDGE, LVL_RISE, rise_at, 1'b0, R_NONE);
                    sent += 2;
                    // now and then a second rise retakes the time
                    if ($urandom_range(0, 19) == 0)
                    begin
                        rise_at += $urandom_range(0, 300);
                        send_event(FUNC_EDGE, LVL_RISE, rise_at, 1'b0, R_NONE);
                        sent++;
                    end
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // echo never falls: next tick resets the sensor
                        now_us = rise_at + $urandom_range(1, 100000);
                        send_event(FUNC_TICK, 1'($urandom()), now_us, 1'b0, R_NONE);
                        sent++;
                    end
                    else
                    begin
                        case ($urandom_range(0, 9))
                            0:       width = TIME_W'(tmo_reg);
                            1:       width = TIME_W'(tmo_reg) + 1;
                            2:       width = '0;
                            3:       width = $urandom();
                            default: width = $urandom_range(0, tmo_reg);
                        endcase
                        now_us = rise_at + width;
                        send_event(FUNC_EDGE, LVL_FALL, now_us, 1'b0, R_NONE);
                        sent++;
                    end
                end
                else
                begin
                    send_event(1'($urandom()), 1'($urandom()), $urandom(), 1'b0, R_NONE);
                    sent++;
                end
            end
        end

        // Drain and let the pipeline run empty
        settle_pipeline();
        repeat (8) @(posedge clk);

        $display("run covered %0d result words: %0d distances (%0d saturated), ",
                 n_results, n_dist, n_sat);
        $display("  %0d echo timeouts, %0d sensor resets over eight register settings",
                 n_tmo, n_srst);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
